[rtl/core/feret_diameter_calipers_top_assert.svh]
// Assertion macros for the feret diameter calipers block.
// Used by files that carry concurrent checks; expects clk and rst_n in scope.
`ifndef FERET_DIAMETER_CALIPERS_TOP_ASSERT_SVH
`define FERET_DIAMETER_CALIPERS_TOP_ASSERT_SVH

// same-cycle implication
`define FDC_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FDC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/fdc_pkg.sv]
// Shared constants and types for the feret diameter calipers block.
// No dependencies.
package fdc_pkg;

  localparam int MAX_VERTICES = 256;
  localparam int COORD_BITS   = 12;
  localparam int FRAC_BITS    = 8;

  localparam int IDX_W  = $clog2(MAX_VERTICES);
  localparam int CNT_W  = IDX_W + 1;
  localparam int OUT_W  = 21;
  localparam logic [63:0] OUT_MAX = (64'd1 << OUT_W) - 64'd1;

  // squared distance width: wide enough for the pair distances and the min cap
  localparam int D2_NAT = 2 * COORD_BITS + 1;
  localparam int D2_W   = (D2_NAT > 27) ? D2_NAT : 27;
  localparam logic [D2_W-1:0] MIN_CAP_SQ = D2_W'(64'd9999 * 64'd9999);

  // root saturates above this squared distance
  localparam logic [63:0] ROOT_LIM = ((OUT_MAX * OUT_MAX) + OUT_MAX) >> (2 * FRAC_BITS);

  localparam int RV_W    = D2_W + 2 * FRAC_BITS;
  localparam int ROOT_N  = (RV_W + 1) / 2;

  // signed operand, product and accumulator widths of the shared multiplier
  localparam int SW = COORD_BITS + 1;
  localparam int PW = 2 * SW;
  localparam int AW = PW + 2;

  typedef struct packed {
    logic            start;
    logic [D2_W-1:0] value;
  } fdc_root_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [OUT_W-1:0] result;
  } fdc_root_rsp_t;

endpackage

[rtl/core/fdc_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module fdc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

[rtl/core/fdc_root.sv]
// Iterative rounded square root in fixed point, one result bit per cycle.
// Depends on fdc_pkg.
module fdc_root
  import fdc_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  fdc_root_req_t req,
  output fdc_root_rsp_t rsp
);

  localparam logic [1:0] R_IDLE = 2'd0;
  localparam logic [1:0] R_RUN  = 2'd1;
  localparam logic [1:0] R_RND  = 2'd2;
  localparam int CW = $clog2(ROOT_N + 1);

  logic [1:0]          st_r, st_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic [2*ROOT_N-1:0] v_r, v_nxt;
  logic [ROOT_N-1:0]   root_r, root_nxt;
  logic [ROOT_N+1:0]   rem_r, rem_nxt;
  logic                done_r, done_nxt;
  logic [OUT_W-1:0]    res_r, res_nxt;

  logic [ROOT_N+3:0]   t;
  logic [ROOT_N+3:0]   trial;
  logic [ROOT_N:0]     rsum;

  always_comb begin
    st_nxt   = st_r;
    cnt_nxt  = cnt_r;
    v_nxt    = v_r;
    root_nxt = root_r;
    rem_nxt  = rem_r;
    done_nxt = 1'b0;
    res_nxt  = res_r;
    t        = {rem_r, v_r[2*ROOT_N-1 -: 2]};
    trial    = (ROOT_N+4)'({root_r, 2'b01});
    rsum     = (ROOT_N+1)'(root_r) + (ROOT_N+1)'((ROOT_N+2)'(root_r) < rem_r);
    unique case (st_r)
      R_IDLE: begin
        if (req.start) begin
          if (64'(req.value) > ROOT_LIM) begin
            res_nxt  = OUT_W'(OUT_MAX);
            done_nxt = 1'b1;
          end else begin
            v_nxt    = (2*ROOT_N)'(RV_W'(req.value) << (2 * FRAC_BITS));
            root_nxt = '0;
            rem_nxt  = '0;
            cnt_nxt  = CW'(ROOT_N);
            st_nxt   = R_RUN;
          end
        end
      end
      R_RUN: begin
        v_nxt = v_r << 2;
        if (t >= trial) begin
          rem_nxt  = (ROOT_N+2)'(t - trial);
          root_nxt = {root_r[ROOT_N-2:0], 1'b1};
        end else begin
          rem_nxt  = (ROOT_N+2)'(t);
          root_nxt = {root_r[ROOT_N-2:0], 1'b0};
        end
        cnt_nxt = cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          st_nxt = R_RND;
        end
      end
      R_RND: begin
        res_nxt  = (64'(rsum) > OUT_MAX) ? OUT_W'(OUT_MAX) : OUT_W'(rsum);
        done_nxt = 1'b1;
        st_nxt   = R_IDLE;
      end
      default: st_nxt = R_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= R_IDLE;
      done_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      done_r <= done_nxt;
    end
    cnt_r  <= cnt_nxt;
    v_r    <= v_nxt;
    root_r <= root_nxt;
    rem_r  <= rem_nxt;
    res_r  <= res_nxt;
  end

  assign rsp.busy   = (st_r != R_IDLE);
  assign rsp.done   = done_r;
  assign rsp.result = res_r;

endmodule

[rtl/core/feret_diameter_calipers_top.sv]
// Min/max Feret diameter of one convex hull by rotating calipers.
// Depends on fdc_pkg, fdc_ram, fdc_root and the assertion macro header.
//
// Usage:
//  - Input channel (in_*): one hull vertex per transfer, in_last_vertex on
//    the final one; in_empty_set ends a hull without adding a vertex.
//  - Output channel (out_*): one result per hull: min and max diameter in
//    unsigned fixed point (FRAC_BITS fraction bits) and an overflow status.
//  - Loading accepts one vertex per cycle. After the closing transfer the
//    block stalls its input while it walks the antipodal pairs.
//  - Every area and every pair distance fetches three vertices from the
//    vertex RAM (one read port, registered data) and then runs the shared
//    multiplier.
//  - The two roots then run one after another on the bit-serial root unit.
//  - The result sits in an output register; loading of the next hull
//    resumes at once. A hull that finishes while the previous result is
//    still stalled waits until that result has been taken.
//  - Reset (rst_n low, synchronous) empties the vertex count, clears the
//    overflow flag and the output valid; the vertex RAM is not cleared.
`include "feret_diameter_calipers_top_assert.svh"
module feret_diameter_calipers_top
  import fdc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [COORD_BITS-1:0] in_x_coord,
  input  logic [COORD_BITS-1:0] in_y_coord,
  input  logic                  in_last_vertex,
  input  logic                  in_empty_set,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [OUT_W-1:0]      out_min_diam,
  output logic [OUT_W-1:0]      out_max_diam,
  output logic                  out_status
);

  // sequencer states
  localparam logic [4:0] S_LOAD   = 5'd0;
  localparam logic [4:0] S_START  = 5'd1;
  localparam logic [4:0] S_KLOOP  = 5'd2;
  localparam logic [4:0] S_K_A1   = 5'd3;
  localparam logic [4:0] S_K_A0   = 5'd4;
  localparam logic [4:0] S_PI     = 5'd5;
  localparam logic [4:0] S_PJ     = 5'd6;
  localparam logic [4:0] S_PJ_A1  = 5'd7;
  localparam logic [4:0] S_PJ_A0  = 5'd8;
  localparam logic [4:0] S_PJ_T   = 5'd9;
  localparam logic [4:0] S_PINC   = 5'd10;
  localparam logic [4:0] S_F0     = 5'd11;
  localparam logic [4:0] S_F1     = 5'd12;
  localparam logic [4:0] S_F2     = 5'd13;
  localparam logic [4:0] S_F3     = 5'd14;
  localparam logic [4:0] S_MUL    = 5'd15;
  localparam logic [4:0] S_RES    = 5'd16;
  localparam logic [4:0] S_RT_MIN = 5'd17;
  localparam logic [4:0] S_RW_MIN = 5'd18;
  localparam logic [4:0] S_RW_MAX = 5'd19;
  localparam logic [4:0] S_FIN    = 5'd20;

  localparam logic OP_AREA = 1'b0;
  localparam logic OP_DIST = 1'b1;

  localparam logic [OUT_W-1:0] ONE_FX = OUT_W'(64'd1 << FRAC_BITS);

  logic [4:0]            state_r, state_nxt;
  logic [4:0]            ret_r, ret_nxt;
  logic                  op_r, op_nxt;
  logic [1:0]            step_r, step_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                  ovf_r, ovf_nxt;
  logic                  two_r, two_nxt;
  logic [D2_W-1:0]       min_r, min_nxt;
  logic [D2_W-1:0]       max_r, max_nxt;
  logic [CNT_W-1:0]      k_r, k_nxt;
  logic [CNT_W-1:0]      i_r, i_nxt;
  logic [CNT_W-1:0]      j_r, j_nxt;
  logic [CNT_W-1:0]      m_r, m_nxt;
  logic [IDX_W-1:0]      idx0_r, idx0_nxt;
  logic [IDX_W-1:0]      idx1_r, idx1_nxt;
  logic [IDX_W-1:0]      idx2_r, idx2_nxt;
  logic [COORD_BITS-1:0] ax_r, ax_nxt, ay_r, ay_nxt;
  logic [COORD_BITS-1:0] bx_r, bx_nxt, by_r, by_nxt;
  logic [COORD_BITS-1:0] cx_r, cx_nxt, cy_r, cy_nxt;
  logic signed [PW-1:0]  prod_r, prod_nxt;
  logic signed [AW-1:0]  acc_r, acc_nxt;
  logic [AW-1:0]         res_r, res_nxt;
  logic [AW-1:0]         a1_r, a1_nxt;
  logic [OUT_W-1:0]      mnf_r, mnf_nxt;
  logic [OUT_W-1:0]      mxf_r, mxf_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]      out_min_r, out_min_nxt;
  logic [OUT_W-1:0]      out_max_r, out_max_nxt;
  logic                  out_status_r, out_status_nxt;

  logic                      in_xfer;
  logic                      ram_we;
  logic                      fin_go;
  logic [IDX_W-1:0]          rd_addr;
  logic [2*COORD_BITS-1:0]   rd_data;
  logic signed [SW-1:0]      opa, opb;
  logic [CNT_W-1:0]          k1, i1;
  logic [D2_W-1:0]           pair_d2;
  fdc_root_req_t             root_req;
  fdc_root_rsp_t             root_rsp;

  function automatic logic signed [SW-1:0] sx(input logic [COORD_BITS-1:0] v);
    return $signed({1'b0, v});
  endfunction

  assign in_stall = (state_r != S_LOAD);
  assign in_xfer  = in_valid && !in_stall;
  assign ram_we   = in_xfer && !in_empty_set && (cnt_r < CNT_W'(MAX_VERTICES));
  // publish the hull result unless the previous one is still stalled
  assign fin_go   = (state_r == S_FIN) && !(out_valid_r && out_stall);

  fdc_ram #(
    .WIDTH (2 * COORD_BITS),
    .DEPTH (MAX_VERTICES)
  ) u_vtx_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (cnt_r[IDX_W-1:0]),
    .wr_data ({in_x_coord, in_y_coord}),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign root_req.start = (state_r == S_RT_MIN) || ((state_r == S_RW_MIN) && root_rsp.done);
  assign root_req.value = (state_r == S_RT_MIN) ? min_r : max_r;

  fdc_root u_root (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (root_req),
    .rsp   (root_rsp)
  );

  // vertex fetch address follows the fetch state
  always_comb begin
    case (state_r)
      S_F0:    rd_addr = idx0_r;
      S_F1:    rd_addr = idx1_r;
      default: rd_addr = idx2_r;
    endcase
  end

  // shared multiplier operands: area terms or coordinate deltas
  always_comb begin
    opa = sx(ax_r);
    opb = sx(by_r) - sx(cy_r);
    if (op_r == OP_DIST) begin
      if (step_r == 2'd0) begin
        opa = sx(ax_r) - sx(bx_r);
        opb = sx(ax_r) - sx(bx_r);
      end else begin
        opa = sx(ay_r) - sx(by_r);
        opb = sx(ay_r) - sx(by_r);
      end
    end else begin
      case (step_r)
        2'd1: begin
          opa = sx(bx_r);
          opb = sx(cy_r) - sx(ay_r);
        end
        2'd2: begin
          opa = sx(cx_r);
          opb = sx(ay_r) - sx(by_r);
        end
        default: begin
          opa = sx(ax_r);
          opb = sx(by_r) - sx(cy_r);
        end
      endcase
    end
  end

  assign k1      = (k_r + CNT_W'(1) < cnt_r) ? k_r + CNT_W'(1) : cnt_r - CNT_W'(1);
  assign i1      = (i_r + CNT_W'(1) < cnt_r) ? i_r + CNT_W'(1) : cnt_r - CNT_W'(1);
  assign pair_d2 = D2_W'($unsigned(acc_r));

  always_comb begin
    state_nxt      = state_r;
    ret_nxt        = ret_r;
    op_nxt         = op_r;
    step_nxt       = step_r;
    cnt_nxt        = cnt_r;
    ovf_nxt        = ovf_r;
    two_nxt        = two_r;
    min_nxt        = min_r;
    max_nxt        = max_r;
    k_nxt          = k_r;
    i_nxt          = i_r;
    j_nxt          = j_r;
    m_nxt          = m_r;
    idx0_nxt       = idx0_r;
    idx1_nxt       = idx1_r;
    idx2_nxt       = idx2_r;
    ax_nxt         = ax_r;
    ay_nxt         = ay_r;
    bx_nxt         = bx_r;
    by_nxt         = by_r;
    cx_nxt         = cx_r;
    cy_nxt         = cy_r;
    prod_nxt       = prod_r;
    acc_nxt        = acc_r;
    res_nxt        = res_r;
    a1_nxt         = a1_r;
    mnf_nxt        = mnf_r;
    mxf_nxt        = mxf_r;
    out_valid_nxt  = out_valid_r;
    out_min_nxt    = out_min_r;
    out_max_nxt    = out_max_r;
    out_status_nxt = out_status_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_LOAD: begin
        if (in_xfer) begin
          if (in_empty_set) begin
            state_nxt = S_START;
          end else begin
            if (cnt_r < CNT_W'(MAX_VERTICES)) begin
              cnt_nxt = cnt_r + CNT_W'(1);
            end else begin
              ovf_nxt = 1'b1;
            end
            if (in_last_vertex) begin
              state_nxt = S_START;
            end
          end
        end
      end
      S_START: begin
        m_nxt = cnt_r - CNT_W'(1);
        k_nxt = CNT_W'(1);
        if (cnt_r < CNT_W'(2)) begin
          mnf_nxt   = '0;
          mxf_nxt   = '0;
          state_nxt = S_FIN;
        end else if (cnt_r == CNT_W'(2)) begin
          two_nxt   = 1'b1;
          idx0_nxt  = '0;
          idx1_nxt  = IDX_W'(1);
          op_nxt    = OP_DIST;
          ret_nxt   = S_RT_MIN;
          state_nxt = S_F0;
        end else begin
          state_nxt = S_KLOOP;
        end
      end
      // find the vertex farthest from the closing edge
      S_KLOOP: begin
        idx0_nxt  = m_r[IDX_W-1:0];
        idx1_nxt  = '0;
        idx2_nxt  = k1[IDX_W-1:0];
        op_nxt    = OP_AREA;
        ret_nxt   = S_K_A1;
        state_nxt = S_F0;
      end
      S_K_A1: begin
        a1_nxt    = res_r;
        idx2_nxt  = k_r[IDX_W-1:0];
        ret_nxt   = S_K_A0;
        state_nxt = S_F0;
      end
      S_K_A0: begin
        if (a1_r > res_r) begin
          k_nxt     = k_r + CNT_W'(1);
          state_nxt = S_KLOOP;
        end else begin
          i_nxt     = '0;
          j_nxt     = k_r;
          state_nxt = S_PI;
        end
      end
      // antipodal pair walk
      S_PI: begin
        if (i_r <= k_r && j_r <= m_r) begin
          idx0_nxt  = i_r[IDX_W-1:0];
          idx1_nxt  = j_r[IDX_W-1:0];
          op_nxt    = OP_DIST;
          ret_nxt   = S_PJ;
          state_nxt = S_F0;
        end else begin
          state_nxt = S_RT_MIN;
        end
      end
      S_PJ: begin
        if (j_r < m_r) begin
          idx0_nxt  = i_r[IDX_W-1:0];
          idx1_nxt  = i1[IDX_W-1:0];
          idx2_nxt  = IDX_W'(j_r + CNT_W'(1));
          op_nxt    = OP_AREA;
          ret_nxt   = S_PJ_A1;
          state_nxt = S_F0;
        end else begin
          state_nxt = S_PINC;
        end
      end
      S_PJ_A1: begin
        a1_nxt    = res_r;
        idx2_nxt  = j_r[IDX_W-1:0];
        ret_nxt   = S_PJ_A0;
        state_nxt = S_F0;
      end
      S_PJ_A0: begin
        if (a1_r > res_r) begin
          idx0_nxt  = i_r[IDX_W-1:0];
          idx1_nxt  = IDX_W'(j_r + CNT_W'(1));
          op_nxt    = OP_DIST;
          ret_nxt   = S_PJ_T;
          state_nxt = S_F0;
        end else begin
          state_nxt = S_PINC;
        end
      end
      S_PJ_T: begin
        j_nxt     = j_r + CNT_W'(1);
        state_nxt = S_PJ;
      end
      S_PINC: begin
        i_nxt     = i_r + CNT_W'(1);
        state_nxt = S_PI;
      end
      // vertex fetch, registered read data arrives in the cycle after its address
      S_F0: begin
        state_nxt = S_F1;
      end
      S_F1: begin
        {ax_nxt, ay_nxt} = rd_data;
        state_nxt        = S_F2;
      end
      S_F2: begin
        {bx_nxt, by_nxt} = rd_data;
        state_nxt        = S_F3;
      end
      S_F3: begin
        {cx_nxt, cy_nxt} = rd_data;
        step_nxt         = '0;
        acc_nxt          = '0;
        state_nxt        = S_MUL;
      end
      S_MUL: begin
        prod_nxt = opa * opb;
        if (step_r != 2'd0) begin
          acc_nxt = acc_r + AW'(prod_r);
        end
        step_nxt = step_r + 2'd1;
        if ((op_r == OP_AREA && step_r == 2'd3) || (op_r == OP_DIST && step_r == 2'd2)) begin
          state_nxt = S_RES;
        end
      end
      S_RES: begin
        if (op_r == OP_DIST) begin
          if (pair_d2 > max_r) max_nxt = pair_d2;
          if (pair_d2 < min_r) min_nxt = pair_d2;
        end else begin
          res_nxt = (acc_r < 0) ? AW'($unsigned(-acc_r)) : AW'($unsigned(acc_r));
        end
        state_nxt = ret_r;
      end
      // rounded roots, min first
      S_RT_MIN: begin
        state_nxt = S_RW_MIN;
      end
      S_RW_MIN: begin
        if (root_rsp.done) begin
          mnf_nxt   = two_r ? ONE_FX : root_rsp.result;
          state_nxt = S_RW_MAX;
        end
      end
      S_RW_MAX: begin
        if (root_rsp.done) begin
          mxf_nxt   = root_rsp.result;
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (fin_go) begin
          out_valid_nxt  = 1'b1;
          out_min_nxt    = mnf_r;
          out_max_nxt    = mxf_r;
          out_status_nxt = ovf_r;
          cnt_nxt        = '0;
          ovf_nxt        = 1'b0;
          two_nxt        = 1'b0;
          min_nxt        = MIN_CAP_SQ;
          max_nxt        = '0;
          state_nxt      = S_LOAD;
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      two_r       <= 1'b0;
      min_r       <= MIN_CAP_SQ;
      max_r       <= '0;
      out_valid_r <= 1'b0;
      ret_r       <= S_LOAD;
      op_r        <= OP_AREA;
      step_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      ovf_r       <= ovf_nxt;
      two_r       <= two_nxt;
      min_r       <= min_nxt;
      max_r       <= max_nxt;
      out_valid_r <= out_valid_nxt;
      ret_r       <= ret_nxt;
      op_r        <= op_nxt;
      step_r      <= step_nxt;
    end
    k_r          <= k_nxt;
    i_r          <= i_nxt;
    j_r          <= j_nxt;
    m_r          <= m_nxt;
    idx0_r       <= idx0_nxt;
    idx1_r       <= idx1_nxt;
    idx2_r       <= idx2_nxt;
    ax_r         <= ax_nxt;
    ay_r         <= ay_nxt;
    bx_r         <= bx_nxt;
    by_r         <= by_nxt;
    cx_r         <= cx_nxt;
    cy_r         <= cy_nxt;
    prod_r       <= prod_nxt;
    acc_r        <= acc_nxt;
    res_r        <= res_nxt;
    a1_r         <= a1_nxt;
    mnf_r        <= mnf_nxt;
    mxf_r        <= mxf_nxt;
    out_min_r    <= out_min_nxt;
    out_max_r    <= out_max_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_min_diam = out_min_r;
  assign out_max_diam = out_max_r;
  assign out_status   = out_status_r;

  `FDC_ASSERT(a_cnt_bound, 1'b1, cnt_r <= CNT_W'(MAX_VERTICES), "vertex count past store depth")
  `FDC_ASSERT(a_root_busy, root_rsp.busy, state_r == S_RW_MIN || state_r == S_RW_MAX, "root busy")
  `FDC_ASSERT(a_j_bound, state_r == S_PJ, j_r <= m_r, "pair index beyond last vertex")
  `FDC_ASSERT_NEXT(a_fin_clear, fin_go, cnt_r == '0 && out_valid_r, "hull end did not publish")

endmodule
